// File: rtl/pst_pkg.sv
package pst_pkg;

    localparam int SLOT_COUNT_DEF = 16;

    localparam int CMD_W  = 3;
    localparam int PID_W  = 32;
    localparam int SLOT_W = 4;
    localparam int CODE_W = 64;

    // request payload: pid, slot, exit_val from bit 0 up, padded to whole bytes
    localparam int IN_DATA_W  = ((PID_W + SLOT_W + CODE_W + 7) / 8) * 8;
    // result payload: slot_out, pid_out from bit 0 up, padded to whole bytes
    localparam int OUT_DATA_W = ((SLOT_W + PID_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 3'd0,
        CMD_FIND    = 3'd1,
        CMD_EXIT    = 3'd2,
        CMD_RELEASE = 3'd3,
        CMD_REAP    = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_UNUSED  = 2'd0,
        ST_CREATED = 2'd1,
        ST_EXITED  = 2'd2
    } t_slot_st;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture the request, rewind the scan
        logic alloc_step;  // test one slot for allocate
        logic find_step;   // issue one read / compare one slot for find
        logic apply;       // apply the update: exit, release, reap
        logic push;        // move the result into the output register
    } t_dp_ctl;

    // datapath to controller
    typedef struct packed {
        logic alloc_done;
        logic find_done;
        logic out_busy;
    } t_dp_stat;

endpackage

// File: rtl/pst_ram.sv
module pst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                        i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                        o_rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr[AW-1:0]];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/pst_ctrl.sv
module pst_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic [pst_pkg::CMD_W-1:0] i_cmd,
    output logic                     o_in_ready,
    input  pst_pkg::t_dp_stat        i_stat,
    output pst_pkg::t_dp_ctl         o_ctl
);
    import pst_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_FIND,
        S_APPLY,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_ctl            = '0;
        o_ctl.load       = (r_state == S_IDLE) && i_in_valid;
        o_ctl.alloc_step = (r_state == S_ALLOC);
        o_ctl.find_step  = (r_state == S_FIND);
        o_ctl.apply      = (r_state == S_APPLY);
        o_ctl.push       = (r_state == S_DONE) && !i_stat.out_busy;
        o_in_ready       = (r_state == S_IDLE);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_cmd)
                        CMD_ALLOC: n_state = S_ALLOC;
                        CMD_FIND:  n_state = S_FIND;
                        default:   n_state = S_APPLY;
                    endcase
                end
            end
            S_ALLOC: begin
                if (i_stat.alloc_done) n_state = S_DONE;
            end
            S_FIND: begin
                if (i_stat.find_done) n_state = S_DONE;
            end
            S_APPLY: n_state = S_DONE;
            S_DONE: begin
                if (!i_stat.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/pst_dp.sv
module pst_dp #(
    parameter int SLOT_COUNT = pst_pkg::SLOT_COUNT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pst_pkg::t_dp_ctl           i_ctl,
    output pst_pkg::t_dp_stat          o_stat,
    input  logic [pst_pkg::CMD_W-1:0]  i_cmd,
    input  logic [pst_pkg::PID_W-1:0]  i_pid,
    input  logic [pst_pkg::SLOT_W-1:0] i_slot,
    input  logic [pst_pkg::CODE_W-1:0] i_exit_val,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic                       o_found,
    output logic [pst_pkg::SLOT_W-1:0] o_slot_out,
    output logic [pst_pkg::PID_W-1:0]  o_pid_out
);
    import pst_pkg::*;

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IW-1:0] LAST = IW'(SLOT_COUNT - 1);

    // slot state and an "identifier reads as zero" flag live in flops so that
    // reset and reap clear them at once; identifiers and codes sit in RAM
    t_slot_st          r_st   [SLOT_COUNT];
    logic              r_idz  [SLOT_COUNT];
    logic [PID_W-1:0]  r_next_ident;

    t_cmd              r_cmd;
    logic [PID_W-1:0]  r_pid;
    logic [IW-1:0]     r_slot_idx;
    logic              r_slot_ok;
    logic [CODE_W-1:0] r_code;

    logic [IW-1:0]     r_idx;
    logic [IW-1:0]     r_cmp_idx;
    logic              r_cmp_vld;
    logic              r_hit;
    logic [IW-1:0]     r_res_idx;
    logic [PID_W-1:0]  r_res_id;

    logic              r_out_valid;
    logic              r_out_found;
    logic [SLOT_W-1:0] r_out_slot;
    logic [PID_W-1:0]  r_out_pid;

    logic [IW+SLOT_W-1:0] slot_ext;
    logic [IW+SLOT_W-1:0] res_ext;
    logic [IW-1:0]        sel_idx;
    t_slot_st             sel_st;
    logic [PID_W-1:0]     id_rd;
    logic [PID_W-1:0]     cmp_ident;
    logic                 alloc_free;
    logic                 find_match;
    logic                 code_wr_en;
    logic [IW-1:0]        code_wr_addr;
    logic [CODE_W-1:0]    code_wr_data;

    assign slot_ext = {{IW{1'b0}}, i_slot};
    assign res_ext  = {{SLOT_W{1'b0}}, r_res_idx};

    assign sel_idx    = i_ctl.alloc_step ? r_idx : r_cmp_idx;
    assign sel_st     = r_st[sel_idx];
    assign cmp_ident  = r_idz[r_cmp_idx] ? '0 : id_rd;
    assign alloc_free = i_ctl.alloc_step && (sel_st == ST_UNUSED);
    assign find_match = i_ctl.find_step && r_cmp_vld && (sel_st != ST_UNUSED)
                        && (cmp_ident == r_pid);

    assign o_stat.alloc_done = alloc_free || (r_idx == LAST);
    assign o_stat.find_done  = find_match || (r_cmp_vld && (r_cmp_idx == LAST));
    assign o_stat.out_busy   = r_out_valid && !i_out_ready;

    // allocate zeroes the code; exit writes it; release zeroes it
    always_comb begin
        code_wr_en   = 1'b0;
        code_wr_addr = r_slot_idx;
        code_wr_data = '0;
        if (alloc_free) begin
            code_wr_en   = 1'b1;
            code_wr_addr = r_idx;
        end else if (i_ctl.apply && r_slot_ok) begin
            if (r_cmd == CMD_EXIT) begin
                code_wr_en   = 1'b1;
                code_wr_data = r_code;
            end else if (r_cmd == CMD_RELEASE) begin
                code_wr_en   = 1'b1;
            end
        end
    end

    pst_ram #(
        .WIDTH (PID_W),
        .DEPTH (SLOT_COUNT)
    ) u_ident_ram (
        .i_clk     (i_clk),
        .i_wr_en   (alloc_free),
        .i_wr_addr (r_idx),
        .i_wr_data (r_next_ident),
        .i_rd_addr (r_idx),
        .o_rd_data (id_rd)
    );

    pst_ram #(
        .WIDTH (CODE_W),
        .DEPTH (SLOT_COUNT)
    ) u_code_ram (
        .i_clk     (i_clk),
        .i_wr_en   (code_wr_en),
        .i_wr_addr (code_wr_addr),
        .i_wr_data (code_wr_data),
        .i_rd_addr (code_wr_addr),
        .o_rd_data ()
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_st[i]  <= ST_UNUSED;
                r_idz[i] <= 1'b1;
            end
            r_next_ident <= PID_W'(1);
            r_out_valid  <= 1'b0;
        end else begin
            if (i_ctl.load) begin
                r_cmd      <= t_cmd'(i_cmd);
                r_pid      <= i_pid;
                r_slot_idx <= slot_ext[IW-1:0];
                r_slot_ok  <= (slot_ext < (IW+SLOT_W)'(SLOT_COUNT));
                r_code     <= i_exit_val;
                r_idx      <= '0;
                r_cmp_vld  <= 1'b0;
                r_hit      <= 1'b0;
                r_res_idx  <= '0;
                r_res_id   <= '0;
            end

            if (i_ctl.alloc_step) begin
                if (alloc_free) begin
                    r_st[r_idx]  <= ST_CREATED;
                    r_idz[r_idx] <= 1'b0;
                    r_hit        <= 1'b1;
                    r_res_idx    <= r_idx;
                    r_res_id     <= r_next_ident;
                    r_next_ident <= r_next_ident + PID_W'(1);
                end else if (r_idx != LAST) begin
                    r_idx <= r_idx + IW'(1);
                end
            end

            // read runs one slot ahead of the compare
            if (i_ctl.find_step) begin
                if (r_idx != LAST) begin
                    r_idx <= r_idx + IW'(1);
                end
                r_cmp_idx <= r_idx;
                r_cmp_vld <= 1'b1;
                if (find_match) begin
                    r_hit     <= 1'b1;
                    r_res_idx <= r_cmp_idx;
                    r_res_id  <= cmp_ident;
                end
            end

            if (i_ctl.apply) begin
                unique case (r_cmd)
                    CMD_EXIT: begin
                        if (r_slot_ok) r_st[r_slot_idx] <= ST_EXITED;
                    end
                    CMD_RELEASE: begin
                        if (r_slot_ok) begin
                            r_st[r_slot_idx]  <= ST_UNUSED;
                            r_idz[r_slot_idx] <= 1'b1;
                        end
                    end
                    CMD_REAP: begin
                        // stale codes of reaped slots are never read back
                        for (int i = 0; i < SLOT_COUNT; i++) begin
                            if (r_st[i] == ST_EXITED) begin
                                r_st[i]  <= ST_UNUSED;
                                r_idz[i] <= 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end

            if (i_ctl.push) begin
                r_out_valid <= 1'b1;
                r_out_found <= r_hit;
                r_out_slot  <= res_ext[SLOT_W-1:0];
                r_out_pid   <= r_res_id;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_out_found;
    assign o_slot_out  = r_out_slot;
    assign o_pid_out   = r_out_pid;

endmodule

// File: rtl/process_slot_table.sv
// Process slot table: SLOT_COUNT slots, each unused, created or exited, with
// a 32-bit identifier and a 64-bit exit code, plus a running identifier
// counter that starts at one and wraps. Each request gives exactly one
// result. Allocate takes the lowest unused slot (found = 1, its index and new
// identifier); find returns the lowest in-use slot holding the requested
// identifier; mark exited, release, reap and undefined commands answer all
// zero. A request is taken only while the block is idle; it is captured as
// it is taken, then worked on, and its result is handed to the output
// register. Allocate scans one slot a cycle; find streams the identifier RAM
// with its registered read, one slot a cycle, the compare running one slot
// behind the read; mark exited, release and reap update the table in the
// apply state, reap clearing all exited slots at once. A finished result
// waits in the output register while the next request is already taken. No
// clearing pass is needed after reset: slot state and a per-slot
// zero-identifier flag are flip-flops that reset clears.
module process_slot_table #(
    parameter int SLOT_COUNT = pst_pkg::SLOT_COUNT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // pid [31:0], slot [35:32], exit_val [99:36], zero padding above
    input  logic [pst_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // cmd [2:0]
    input  logic [pst_pkg::CMD_W-1:0]        s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // slot_out [3:0], pid_out [35:4], zero padding above
    output logic [pst_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // found [0]
    output logic [0:0]                       m_axis_tuser
);
    import pst_pkg::*;

    t_dp_ctl           ctl;
    t_dp_stat          stat;
    logic [PID_W-1:0]  in_pid;
    logic [SLOT_W-1:0] in_slot;
    logic [CODE_W-1:0] in_code;
    logic              out_found;
    logic [SLOT_W-1:0] out_slot;
    logic [PID_W-1:0]  out_pid;

    // unpack the request
    assign in_pid  = s_axis_tdata[PID_W-1:0];
    assign in_slot = s_axis_tdata[PID_W +: SLOT_W];
    assign in_code = s_axis_tdata[PID_W+SLOT_W +: CODE_W];

    // sequence each request: capture, scan or update, hand over the result
    pst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_cmd      (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_ctl      (ctl)
    );

    // slot table, identifier counter and output register
    pst_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_stat      (stat),
        .i_cmd       (s_axis_tuser),
        .i_pid       (in_pid),
        .i_slot      (in_slot),
        .i_exit_val  (in_code),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_found     (out_found),
        .o_slot_out  (out_slot),
        .o_pid_out   (out_pid)
    );

    // pack the result, padding with zeros
    assign m_axis_tdata = {{(OUT_DATA_W - SLOT_W - PID_W){1'b0}}, out_pid, out_slot};
    assign m_axis_tuser = out_found;

endmodule

// File: tb/process_slot_table_tb.sv
module process_slot_table_tb;
    import pst_pkg::*;

    localparam int SLOTS           = SLOT_COUNT_DEF;
    localparam int CLK_HALF        = 10;
    // generous limit on the length of the whole run
    localparam int CYCLE_LIMIT     = 400000;
    // room for a full find scan with its capture and push, doubled
    localparam int TAIL_CYCLES     = 2 * (SLOTS + 4);
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int BURST_ITEMS     = 20;
    localparam int ITEMS_PER_PHASE = 230;
    localparam int PAD_W           = IN_DATA_W - PID_W - SLOT_W - CODE_W;

    typedef struct {
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic [PID_W-1:0]  pid;
    } t_slot_answer;

    // Mirror of the slot table: predict each answer as a request is taken,
    // queue it, and compare results against the oldest queued answer.
    class slot_table_scoreboard;
        t_slot_st          slot_state [SLOTS];
        logic [PID_W-1:0]  slot_ident [SLOTS];
        logic [CODE_W-1:0] slot_code  [SLOTS];
        logic [PID_W-1:0]  next_ident;
        t_slot_answer      answers_due [$];
        int                mismatch_count;

        function new();
            for (int i = 0; i < SLOTS; i++)
                clear_slot(i);
            next_ident     = 1;
            mismatch_count = 0;
        endfunction

        function void clear_slot(int i);
            slot_state[i] = ST_UNUSED;
            slot_ident[i] = '0;
            slot_code[i]  = '0;
        endfunction

        function int pending();
            return answers_due.size();
        endfunction

        function void note_request(logic [CMD_W-1:0] cmd, logic [PID_W-1:0] pid,
                                   logic [SLOT_W-1:0] slot, logic [CODE_W-1:0] code);
            t_slot_answer ans;
            ans = '{1'b0, '0, '0};
            case (cmd)
                CMD_ALLOC: begin
                    for (int i = 0; i < SLOTS && !ans.found; i++) begin
                        if (slot_state[i] == ST_UNUSED) begin
                            clear_slot(i);
                            slot_ident[i] = next_ident;
                            slot_state[i] = ST_CREATED;
                            next_ident    = next_ident + 1;
                            ans = '{1'b1, SLOT_W'(i), slot_ident[i]};
                        end
                    end
                end
                CMD_FIND: begin
                    for (int i = 0; i < SLOTS && !ans.found; i++) begin
                        if (slot_state[i] != ST_UNUSED && slot_ident[i] == pid)
                            ans = '{1'b1, SLOT_W'(i), slot_ident[i]};
                    end
                end
                CMD_EXIT: begin
                    if (int'(slot) < SLOTS) begin
                        slot_code[slot]  = code;
                        slot_state[slot] = ST_EXITED;
                    end
                end
                CMD_RELEASE: begin
                    if (int'(slot) < SLOTS)
                        clear_slot(slot);
                end
                CMD_REAP: begin
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_state[i] == ST_EXITED)
                            clear_slot(i);
                end
                default: ;
            endcase
            answers_due.push_back(ans);
        endfunction

        task report_mismatch(string what);
            mismatch_count++;
            $display("mismatch: %s", what);
        endtask

        task check_result(logic found, logic [SLOT_W-1:0] slot,
                          logic [PID_W-1:0] pid);
            t_slot_answer due;
            if (answers_due.size() == 0) begin
                report_mismatch($sformatf(
                    "result with no request outstanding: found=%0b slot=%0d pid=%h",
                    found, slot, pid));
                return;
            end
            due = answers_due.pop_front();
            if (found !== due.found)
                report_mismatch($sformatf("found %0b, predicted %0b", found, due.found));
            if (slot !== due.slot)
                report_mismatch($sformatf("slot_out %0d, predicted %0d", slot, due.slot));
            if (pid !== due.pid)
                report_mismatch($sformatf("pid_out %h, predicted %h", pid, due.pid));
        endtask
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // pid [31:0], slot [35:32], exit_val [99:36], zero padding above
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    // cmd [2:0]
    logic [CMD_W-1:0]      s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // slot_out [3:0], pid_out [35:4], zero padding above
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // found [0]
    logic [0:0]            m_axis_tuser;

    slot_table_scoreboard sb;
    int cycle_count     = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int hold_off_left   = 0;

    process_slot_table #(.SLOT_COUNT(SLOTS)) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Watchdog: fail the run once the cycle counter reaches CYCLE_LIMIT.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("process_slot_table test failed");
            $finish;
        end
    end

    // Result side: check each accepted result, then pick the next tready.
    // A pending hold-off forces tready low for its whole length, counted
    // down here so that the sender keeps running meanwhile.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tuser[0], m_axis_tdata[SLOT_W-1:0],
                                m_axis_tdata[SLOT_W+PID_W-1:SLOT_W]);
            if (hold_off_left != 0) begin
                hold_off_left <= hold_off_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Offer one request, idling first at the current rate, and note it in
    // the scoreboard at the edge where it is taken. Leave tvalid high: the
    // next call either keeps it up or drops it while it idles.
    task automatic send_request(input logic [CMD_W-1:0]  cmd,
                                input logic [PID_W-1:0]  pid,
                                input logic [SLOT_W-1:0] slot,
                                input logic [CODE_W-1:0] code);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {{PAD_W{1'b0}}, code, slot, pid};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(cmd, pid, slot, code);
    endtask

    // Mostly allocate and find, enough release and reap to keep the table
    // churning, and a few undefined commands. Aim most finds at identifiers
    // the table holds, so that hits are common.
    task automatic send_random_request();
        int                pick;
        int                roll;
        logic [CMD_W-1:0]  cmd;
        logic [PID_W-1:0]  pid;
        logic [SLOT_W-1:0] slot;
        logic [CODE_W-1:0] code;
        pick = $urandom_range(0, 99);
        pid  = $urandom;
        slot = SLOT_W'($urandom);
        code = {$urandom, $urandom};
        if (pick < 30) begin
            cmd = CMD_ALLOC;
        end else if (pick < 60) begin
            cmd  = CMD_FIND;
            roll = $urandom_range(0, 9);
            if (roll < 6)
                pid = sb.slot_ident[$urandom_range(0, SLOTS - 1)];
            else if (roll < 7)
                pid = '0;
            else if (roll < 8)
                pid = sb.next_ident;
        end else if (pick < 75) begin
            cmd = CMD_EXIT;
        end else if (pick < 85) begin
            cmd = CMD_RELEASE;
        end else if (pick < 93) begin
            cmd = CMD_REAP;
        end else begin
            cmd = CMD_W'($urandom_range(5, 7));
        end
        send_request(cmd, pid, slot, code);
    endtask

    // Drop tvalid and hold the sender until every predicted result is in.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, no idling. Fill the table and go one past full.
        for (int i = 0; i <= SLOTS; i++)
            send_request(CMD_ALLOC, $urandom, SLOT_W'($urandom), {$urandom, $urandom});
        send_request(CMD_FIND, 32'd1, 4'd0, '0);
        send_request(CMD_FIND, 32'hFFFF_FFFF, 4'hF, '1);
        // exit code extremes, then overwrite an exited slot's code
        send_request(CMD_EXIT, '0, 4'd0, 64'h8000_0000_0000_0000);
        send_request(CMD_EXIT, '1, 4'hF, 64'h7FFF_FFFF_FFFF_FFFF);
        send_request(CMD_EXIT, '0, 4'hF, '1);
        // an exited slot still answers find
        send_request(CMD_FIND, 32'd1, 4'd0, '0);
        send_request(CMD_RELEASE, '0, 4'd3, '0);
        send_request(CMD_ALLOC, '0, 4'd0, '0);
        send_request(CMD_REAP, '1, 4'hF, '1);
        // slot 15 is unused again after the reap
        send_request(CMD_RELEASE, '0, 4'hF, '0);
        // mark an unused slot exited: it keeps identifier zero and is findable
        send_request(CMD_EXIT, '0, 4'd0, '0);
        send_request(CMD_FIND, 32'd0, 4'd0, '0);
        send_request(CMD_W'(5), '1, 4'hF, '1);
        send_request(CMD_W'(7), '1, 4'hF, '1);
        wait_for_results();

        // Back-pressure: hold tready low while requests keep coming, so the
        // block fills and stalls its input; then pause until it has drained.
        hold_off_left <= HOLD_OFF_CYCLES;
        repeat (BURST_ITEMS)
            send_random_request();
        wait_for_results();

        // Random phases: no idling, sender idle, receiver stalling, both.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin sender_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            repeat (ITEMS_PER_PHASE)
                send_random_request();
            wait_for_results();
        end

        // Let any stray result show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("process_slot_table test passed");
        else
            $display("process_slot_table test failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/pst_pkg.sv
rtl/pst_ram.sv
rtl/pst_ctrl.sv
rtl/pst_dp.sv
rtl/process_slot_table.sv
tb/process_slot_table_tb.sv
